### rtl/fbsc_pkg.sv
// Shared types, codes and the CRC-32 byte table of the firmware block stream checker.
`default_nettype none

package fbsc_pkg;

    localparam int unsigned WINDOW_SIZE_DEFAULT = 65536;

    localparam logic [31:0] CRC_POLY  = 32'h04C1_1DB7;
    localparam logic [31:0] END_CMD   = 32'h0000_0004;
    localparam logic [11:0] TOP_HIGH  = 12'hC00;
    localparam logic [11:0] TOP_LOW   = 12'h000;
    localparam logic [31:0] TAIL_LEN  = 32'd4;

    typedef enum logic [2:0] {
        PH_HEADER = 3'b001,
        PH_BODY   = 3'b010,
        PH_SKIP   = 3'b100
    } t_phase;

    typedef enum logic [1:0] {
        KIND_WRITE      = 2'd0,
        KIND_BLOCK_OK   = 2'd1,
        KIND_IMAGE_DONE = 2'd2,
        KIND_ERROR      = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        ERR_NONE       = 3'd0,
        ERR_HEADER_CRC = 3'd1,
        ERR_SHORT_LEN  = 3'd2,
        ERR_OVERRUN    = 3'd3,
        ERR_BODY_CRC   = 3'd4,
        ERR_BAD_REGION = 3'd5,
        ERR_RAN_OUT    = 3'd6
    } t_err;

    typedef enum logic [1:0] {
        REGION_LOW     = 2'd0,
        REGION_HIGH    = 2'd1,
        REGION_INVALID = 2'd2
    } t_region;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_item;

    typedef struct packed {
        t_kind       kind;
        logic        region;
        logic [15:0] offset;
        logic [7:0]  data_value;
        t_err        error_code;
        logic [16:0] high_extent;
        logic [16:0] low_extent;
    } t_result;

    typedef logic [31:0] t_crc_table [256];

    // MSB-first CRC-32 remainder of one byte placed in the top of a zero register.
    function automatic t_crc_table build_crc_table();
        t_crc_table  tbl;
        logic [31:0] r;
        for (int i = 0; i < 256; i++) begin
            r = {i[7:0], 24'h0};
            for (int b = 0; b < 8; b++) begin
                if (r[31]) begin
                    r = {r[30:0], 1'b0} ^ CRC_POLY;
                end else begin
                    r = {r[30:0], 1'b0};
                end
            end
            tbl[i] = r;
        end
        return tbl;
    endfunction

    localparam t_crc_table CRC_TABLE = build_crc_table();

endpackage

`default_nettype wire

### rtl/fbsc_if.sv
// Handshake interfaces for the image byte channel and the result channel.
`default_nettype none

interface fbsc_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface fbsc_result_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic        region;
    logic [15:0] offset;
    logic [7:0]  data_value;
    logic [2:0]  error_code;
    logic [16:0] high_extent;
    logic [16:0] low_extent;

    modport source (output valid, output kind, output region, output offset,
                    output data_value, output error_code, output high_extent,
                    output low_extent, input ready);
    modport sink   (input valid, input kind, input region, input offset,
                    input data_value, input error_code, input high_extent,
                    input low_extent, output ready);
endinterface

`default_nettype wire

### rtl/fbsc_in_stage.sv
// Input register that holds one image byte until the parser consumes it.
`default_nettype none

module fbsc_in_stage (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    fbsc_byte_if.sink          i_req,
    input  wire logic          i_advance,
    output fbsc_pkg::t_in_item o_item,
    output logic               o_valid
);

    logic               r_valid;
    fbsc_pkg::t_in_item r_item;

    assign i_req.ready = !r_valid || i_advance;
    assign o_valid     = r_valid;
    assign o_item      = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_req.ready) begin
            r_valid <= i_req.valid;
        end
        if (i_req.ready && i_req.valid) begin
            r_item.data_byte <= i_req.data_byte;
            r_item.last_byte <= i_req.last_byte;
        end
    end

endmodule

`default_nettype wire

### rtl/fbsc_parser.sv
// Block parser: header capture, CRC checking, payload writes and extent tracking.
`default_nettype none

module fbsc_parser #(
    parameter int unsigned WINDOW_SIZE = fbsc_pkg::WINDOW_SIZE_DEFAULT
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_advance,
    input  wire fbsc_pkg::t_in_item i_item,
    output logic                    o_res_valid,
    output fbsc_pkg::t_result       o_res
);

    fbsc_pkg::t_phase  r_phase,  n_phase;
    logic [16:0]       r_count,  n_count;
    logic [31:0]       r_cmd,    n_cmd;
    logic [31:0]       r_base,   n_base;
    logic [31:0]       r_len,    n_len;
    logic [31:0]       r_crc,    n_crc;
    logic [15:0]       r_woff,   n_woff;
    fbsc_pkg::t_region r_rflag,  n_rflag;
    logic [16:0]       r_hmax,   n_hmax;
    logic [16:0]       r_lmax,   n_lmax;

    logic [7:0]  d;
    logic [31:0] crc_next;
    logic [3:0]  hidx;
    logic [32:0] hdr_past;
    logic [16:0] cnt_inc;
    logic [16:0] blk_past;
    logic [11:0] top;

    always_comb begin
        d        = i_item.data_byte;
        crc_next = {r_crc[23:0], 8'h00} ^ fbsc_pkg::CRC_TABLE[r_crc[31:24] ^ d];
        hidx     = r_count[3:0];
        hdr_past = {17'b0, r_base[15:0]} + {1'b0, r_len} - {1'b0, fbsc_pkg::TAIL_LEN};
        cnt_inc  = r_count + 17'd1;
        blk_past = {1'b0, r_woff} + r_len[16:0] - fbsc_pkg::TAIL_LEN[16:0];
        top      = r_base[31:20];

        n_phase = r_phase;
        n_count = r_count;
        n_cmd   = r_cmd;
        n_base  = r_base;
        n_len   = r_len;
        n_crc   = r_crc;
        n_woff  = r_woff;
        n_rflag = r_rflag;
        n_hmax  = r_hmax;
        n_lmax  = r_lmax;

        o_res_valid = 1'b0;
        o_res       = '0;

        case (r_phase)
            fbsc_pkg::PH_HEADER: begin
                n_crc   = crc_next;
                n_count = {13'b0, hidx} + 17'd1;
                case (hidx[3:2])
                    2'd0:    n_cmd[8*hidx[1:0] +: 8]  = d;
                    2'd1:    n_base[8*hidx[1:0] +: 8] = d;
                    2'd2:    n_len[8*hidx[1:0] +: 8]  = d;
                    default: ;
                endcase
                if (hidx == 4'd15) begin
                    // Header complete: base and length words are already final.
                    o_res_valid = 1'b1;
                    n_phase     = fbsc_pkg::PH_SKIP;
                    if (crc_next != 32'd0) begin
                        o_res.kind       = fbsc_pkg::KIND_ERROR;
                        o_res.error_code = fbsc_pkg::ERR_HEADER_CRC;
                    end else if (r_cmd == fbsc_pkg::END_CMD && r_len == 32'd0) begin
                        o_res.kind        = fbsc_pkg::KIND_IMAGE_DONE;
                        o_res.high_extent = r_hmax;
                        o_res.low_extent  = r_lmax;
                    end else if (r_len < fbsc_pkg::TAIL_LEN) begin
                        o_res.kind       = fbsc_pkg::KIND_ERROR;
                        o_res.error_code = fbsc_pkg::ERR_SHORT_LEN;
                    end else if (i_item.last_byte) begin
                        o_res.kind       = fbsc_pkg::KIND_ERROR;
                        o_res.error_code = fbsc_pkg::ERR_RAN_OUT;
                    end else if (hdr_past > 33'(WINDOW_SIZE)) begin
                        o_res.kind       = fbsc_pkg::KIND_ERROR;
                        o_res.error_code = fbsc_pkg::ERR_OVERRUN;
                    end else begin
                        o_res_valid = 1'b0;
                        n_phase     = fbsc_pkg::PH_BODY;
                        n_woff      = r_base[15:0];
                        n_crc       = 32'd0;
                        n_count     = 17'd0;
                        if (top == fbsc_pkg::TOP_HIGH) begin
                            n_rflag = fbsc_pkg::REGION_HIGH;
                        end else if (top == fbsc_pkg::TOP_LOW) begin
                            n_rflag = fbsc_pkg::REGION_LOW;
                        end else begin
                            n_rflag = fbsc_pkg::REGION_INVALID;
                        end
                    end
                end else if (i_item.last_byte) begin
                    o_res_valid      = 1'b1;
                    o_res.kind       = fbsc_pkg::KIND_ERROR;
                    o_res.error_code = fbsc_pkg::ERR_RAN_OUT;
                    n_phase          = fbsc_pkg::PH_SKIP;
                end
            end
            fbsc_pkg::PH_BODY: begin
                n_crc   = crc_next;
                n_count = cnt_inc;
                if ({15'b0, cnt_inc} == r_len) begin
                    o_res_valid = 1'b1;
                    if (crc_next != 32'd0) begin
                        o_res.kind       = fbsc_pkg::KIND_ERROR;
                        o_res.error_code = fbsc_pkg::ERR_BODY_CRC;
                        n_phase          = fbsc_pkg::PH_SKIP;
                    end else if (r_rflag == fbsc_pkg::REGION_INVALID) begin
                        o_res.kind       = fbsc_pkg::KIND_ERROR;
                        o_res.error_code = fbsc_pkg::ERR_BAD_REGION;
                        n_phase          = fbsc_pkg::PH_SKIP;
                    end else begin
                        o_res.kind = fbsc_pkg::KIND_BLOCK_OK;
                        n_phase    = fbsc_pkg::PH_HEADER;
                        n_count    = 17'd0;
                        n_crc      = 32'd0;
                        if (r_rflag == fbsc_pkg::REGION_HIGH) begin
                            if (blk_past > r_hmax) begin
                                n_hmax = blk_past;
                            end
                        end else if (blk_past > r_lmax) begin
                            n_lmax = blk_past;
                        end
                    end
                end else if (i_item.last_byte) begin
                    o_res_valid      = 1'b1;
                    o_res.kind       = fbsc_pkg::KIND_ERROR;
                    o_res.error_code = fbsc_pkg::ERR_RAN_OUT;
                    n_phase          = fbsc_pkg::PH_SKIP;
                end else if ({15'b0, r_count} < (r_len - fbsc_pkg::TAIL_LEN) &&
                             r_rflag != fbsc_pkg::REGION_INVALID) begin
                    o_res_valid      = 1'b1;
                    o_res.kind       = fbsc_pkg::KIND_WRITE;
                    o_res.region     = (r_rflag == fbsc_pkg::REGION_HIGH);
                    o_res.offset     = r_woff + r_count[15:0];
                    o_res.data_value = d;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_advance && i_item.last_byte)) begin
            r_phase <= fbsc_pkg::PH_HEADER;
            r_count <= '0;
            r_cmd   <= '0;
            r_base  <= '0;
            r_len   <= '0;
            r_crc   <= '0;
            r_woff  <= '0;
            r_rflag <= fbsc_pkg::REGION_LOW;
            r_hmax  <= '0;
            r_lmax  <= '0;
        end else if (i_advance) begin
            r_phase <= n_phase;
            r_count <= n_count;
            r_cmd   <= n_cmd;
            r_base  <= n_base;
            r_len   <= n_len;
            r_crc   <= n_crc;
            r_woff  <= n_woff;
            r_rflag <= n_rflag;
            r_hmax  <= n_hmax;
            r_lmax  <= n_lmax;
        end
    end

endmodule

`default_nettype wire

### rtl/firmware_block_stream_checker.sv
// Top level of the firmware block stream checker: input register, parser, result register.
// A byte waits in the input register, its result request in the result register.
// Throughput: one byte per cycle unless results stall; CRC table step sets critical path.
// A byte that causes no result still passes through, so gaps appear on the result side.
// Reset: synchronous, active low; it clears both valid flags and all parser state.
// The final byte of an image also returns the parser to its reset state.
`default_nettype none

module firmware_block_stream_checker #(
    parameter int unsigned WINDOW_SIZE = fbsc_pkg::WINDOW_SIZE_DEFAULT
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    fbsc_byte_if.sink     i_req,
    fbsc_result_if.source o_res
);

    // The input register holds the next byte; it refills in the same cycle that the parser
    // consumes it, so a steady stream moves one byte a cycle unless results stall.
    fbsc_pkg::t_in_item in_item;
    logic               in_valid;
    logic               advance;

    // The parser consumes a byte whenever the result register is free or is
    // being emptied in this same cycle.
    logic              res_valid;
    fbsc_pkg::t_result res;

    logic              r_out_valid;
    fbsc_pkg::t_result r_out;

    assign advance = in_valid && (!r_out_valid || o_res.ready);

    fbsc_in_stage u_in_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (i_req),
        .i_advance (advance),
        .o_item    (in_item),
        .o_valid   (in_valid)
    );

    fbsc_parser #(
        .WINDOW_SIZE (WINDOW_SIZE)
    ) u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_advance   (advance),
        .i_item      (in_item),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    // Result register. It loads on every consumed byte, holding a request only
    // when that byte produced one, and otherwise drains when the sink takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= res_valid;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
        if (advance && res_valid) begin
            r_out <= res;
        end
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.kind        = r_out.kind;
    assign o_res.region      = r_out.region;
    assign o_res.offset      = r_out.offset;
    assign o_res.data_value  = r_out.data_value;
    assign o_res.error_code  = r_out.error_code;
    assign o_res.high_extent = r_out.high_extent;
    assign o_res.low_extent  = r_out.low_extent;

endmodule

`default_nettype wire

### dv/fbsc_result_checker.sv
// Watches the image byte and result channels, predicts every result and compares it.
`timescale 1ns / 1ps

module fbsc_result_checker #(
    parameter int unsigned WINDOW_SIZE = fbsc_pkg::WINDOW_SIZE_DEFAULT
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    fbsc_byte_if   i_req,
    fbsc_result_if i_res,
    output int     o_pending,
    output int     o_fail_count
);
    import fbsc_pkg::*;

    // Parser state as the block should hold it.
    t_phase      parse_phase;
    logic [16:0] taken;
    logic [31:0] cmd_word;
    logic [31:0] base_word;
    logic [31:0] len_word;
    logic [31:0] crc_rem;
    logic [15:0] write_base;
    t_region     write_region;
    logic [16:0] high_reach;
    logic [16:0] low_reach;

    t_result     expected_results[$];
    int          fails = 0;
    int          results_seen = 0;

    // Bitwise MSB-first CRC-32 step, initial value zero, no reflection.
    function automatic logic [31:0] crc_feed_byte(input logic [31:0] rem, input logic [7:0] d);
        logic [31:0] r;
        r = rem ^ {d, 24'h0};
        for (int b = 0; b < 8; b++) begin
            r = r[31] ? ({r[30:0], 1'b0} ^ CRC_POLY) : {r[30:0], 1'b0};
        end
        return r;
    endfunction

    task automatic clear_parser();
        parse_phase  = PH_HEADER;
        taken        = '0;
        cmd_word     = '0;
        base_word    = '0;
        len_word     = '0;
        crc_rem      = '0;
        write_base   = '0;
        write_region = REGION_LOW;
        high_reach   = '0;
        low_reach    = '0;
    endtask

    // Advances the parser by one image byte and queues the result it causes, if any.
    task automatic parse_image_byte(input logic [7:0] d, input logic last);
        t_result     r;
        t_err        err;
        logic        produces;
        logic [3:0]  hdr_idx;
        logic [16:0] body_idx;
        logic [33:0] reach;
        logic [31:0] block_end;
        r = '0;
        err = ERR_NONE;
        produces = 1'b0;
        case (parse_phase)
            PH_HEADER: begin
                hdr_idx = taken[3:0];
                crc_rem = crc_feed_byte(crc_rem, d);
                case (hdr_idx[3:2])
                    2'd0: cmd_word[hdr_idx[1:0] * 8 +: 8] = d;
                    2'd1: base_word[hdr_idx[1:0] * 8 +: 8] = d;
                    2'd2: len_word[hdr_idx[1:0] * 8 +: 8] = d;
                    default: ;
                endcase
                taken = {13'd0, hdr_idx} + 17'd1;
                if (taken == 17'd16) begin
                    reach = {18'd0, base_word[15:0]} + {2'd0, len_word} - 34'd4;
                    produces = 1'b1;
                    if (crc_rem != '0) begin
                        err = ERR_HEADER_CRC;
                    end else if (cmd_word == END_CMD && len_word == '0) begin
                        r.kind        = KIND_IMAGE_DONE;
                        r.high_extent = high_reach;
                        r.low_extent  = low_reach;
                        parse_phase   = PH_SKIP;
                    end else if (len_word < TAIL_LEN) begin
                        err = ERR_SHORT_LEN;
                    end else if (last) begin
                        err = ERR_RAN_OUT;
                    end else if (reach > 34'(WINDOW_SIZE)) begin
                        err = ERR_OVERRUN;
                    end else begin
                        produces   = 1'b0;
                        write_base = base_word[15:0];
                        if (base_word[31:20] == TOP_HIGH) begin
                            write_region = REGION_HIGH;
                        end else if (base_word[31:20] == TOP_LOW) begin
                            write_region = REGION_LOW;
                        end else begin
                            write_region = REGION_INVALID;
                        end
                        crc_rem     = '0;
                        taken       = '0;
                        parse_phase = PH_BODY;
                    end
                end else if (last) begin
                    produces = 1'b1;
                    err = ERR_RAN_OUT;
                end
            end
            PH_BODY: begin
                body_idx = taken;
                crc_rem  = crc_feed_byte(crc_rem, d);
                taken    = taken + 17'd1;
                if ({15'd0, taken} == len_word) begin
                    produces = 1'b1;
                    if (crc_rem != '0) begin
                        err = ERR_BODY_CRC;
                    end else if (write_region == REGION_INVALID) begin
                        err = ERR_BAD_REGION;
                    end else begin
                        // The block is good, so its end offset may raise its region's extent.
                        block_end = {16'd0, write_base} + len_word - TAIL_LEN;
                        r.kind = KIND_BLOCK_OK;
                        if (write_region == REGION_HIGH) begin
                            if (block_end > {15'd0, high_reach}) high_reach = block_end[16:0];
                        end else begin
                            if (block_end > {15'd0, low_reach}) low_reach = block_end[16:0];
                        end
                        parse_phase = PH_HEADER;
                        taken       = '0;
                        crc_rem     = '0;
                    end
                end else if (last) begin
                    produces = 1'b1;
                    err = ERR_RAN_OUT;
                end else if ({15'd0, body_idx} < len_word - TAIL_LEN &&
                             write_region != REGION_INVALID) begin
                    produces     = 1'b1;
                    r.kind       = KIND_WRITE;
                    r.region     = (write_region == REGION_HIGH);
                    r.offset     = write_base + body_idx[15:0];
                    r.data_value = d;
                end
            end
            default: ;
        endcase
        if (err != ERR_NONE) begin
            r.kind       = KIND_ERROR;
            r.error_code = err;
            parse_phase  = PH_SKIP;
        end
        if (produces) expected_results.push_back(r);
        if (last) clear_parser();
    endtask

    always @(posedge i_clk) begin
        t_result seen;
        t_result want;
        if (!i_rst_n) begin
            clear_parser();
            expected_results.delete();
        end else begin
            // Results are checked before this edge's request is parsed, since a result
            // can never belong to a request accepted on the same edge.
            if (i_res.valid && i_res.ready) begin
                results_seen++;
                seen.kind        = t_kind'(i_res.kind);
                seen.region      = i_res.region;
                seen.offset      = i_res.offset;
                seen.data_value  = i_res.data_value;
                seen.error_code  = t_err'(i_res.error_code);
                seen.high_extent = i_res.high_extent;
                seen.low_extent  = i_res.low_extent;
                if (expected_results.size() == 0) begin
                    fails++;
                    if (fails <= 10) begin
                        $display("result %0d arrived with none expected: kind %0d error %0d",
                                 results_seen, seen.kind, seen.error_code);
                    end
                end else begin
                    want = expected_results.pop_front();
                    if (seen.kind !== want.kind || seen.region !== want.region ||
                        seen.offset !== want.offset || seen.data_value !== want.data_value ||
                        seen.error_code !== want.error_code ||
                        seen.high_extent !== want.high_extent ||
                        seen.low_extent !== want.low_extent) begin
                        fails++;
                        if (fails <= 10) begin
                            $display("result %0d mismatch (expected/actual):", results_seen);
                            $display("  kind %0d/%0d region %0d/%0d offset %h/%h data %h/%h",
                                     want.kind, seen.kind,
                                     want.region, seen.region, want.offset, seen.offset,
                                     want.data_value, seen.data_value);
                            $display("  error %0d/%0d high %h/%h low %h/%h",
                                     want.error_code, seen.error_code,
                                     want.high_extent, seen.high_extent,
                                     want.low_extent, seen.low_extent);
                        end
                    end
                end
            end
            if (i_req.valid && i_req.ready) begin
                parse_image_byte(i_req.data_byte, i_req.last_byte);
            end
        end
        o_pending    <= expected_results.size();
        o_fail_count <= fails;
    end

endmodule

### dv/testbench.sv
// Top of the test bench: clock, reset, firmware image stimulus, result stalls and the verdict.
`timescale 1ns / 1ps

module testbench;
    import fbsc_pkg::*;

    // Watchdog limit, set well above the length of the slowest correct run.
    localparam int CYCLE_LIMIT  = 400000;
    // Bytes of randomly built images to send after the directed images.
    localparam int RANDOM_BYTES = 120;
    // Chance, in percent, that either side idles on a given cycle outside the calm window.
    localparam int IDLE_PERCENT = 38;

    logic i_clk = 1'b0;
    logic i_rst_n;
    int   cycle_count = 0;
    int   pending_count;
    int   fail_count;
    logic calm;

    fbsc_byte_if   req_if ();
    fbsc_result_if res_if ();

    // The complete byte stream, built before reset is released.
    t_in_item   stream_q[$];
    // Bytes of the block under construction.
    logic [7:0] blk_q[$];
    int         directed_len;
    int         pause_mid;

    firmware_block_stream_checker dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_res   (res_if)
    );

    fbsc_result_checker result_watch (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (req_if),
        .i_res        (res_if),
        .o_pending    (pending_count),
        .o_fail_count (fail_count)
    );

    always #5 i_clk = ~i_clk;

    // A quarter of the time, in a recurring window, neither side idles.
    assign calm = (cycle_count % 1000) >= 300 && (cycle_count % 1000) < 550;

    // Watchdog: a run that stalls past the limit fails.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // The result side stalls at random, outside the calm window.
    always @(negedge i_clk) begin
        res_if.ready <= calm || ($urandom_range(99) >= IDLE_PERCENT);
    end

    // Table-driven CRC step for stimulus; the checker predicts with its own bitwise form.
    function automatic logic [31:0] crc_next(input logic [31:0] rem, input logic [7:0] d);
        return {rem[23:0], 8'h00} ^ CRC_TABLE[rem[31:24] ^ d];
    endfunction

    // Appends the check bytes that bring the remainder to zero, optionally corrupted.
    task automatic push_check_bytes(input logic [31:0] rem, input bit spoil);
        for (int k = 3; k >= 0; k--) begin
            blk_q.push_back(rem[k * 8 +: 8]);
        end
        if (spoil) blk_q[blk_q.size() - 1] ^= 8'($urandom_range(1, 255));
    endtask

    // Builds a header and, if asked, a body with random payload and a matching tail.
    task automatic build_block(input logic [31:0] cmd, input logic [31:0] base,
                               input logic [31:0] len, input bit with_body,
                               input bit spoil_head, input bit spoil_body);
        logic [95:0] words;
        logic [31:0] rem;
        logic [7:0]  b;
        words = {len, base, cmd};
        blk_q.delete();
        rem = '0;
        for (int i = 0; i < 12; i++) begin
            blk_q.push_back(words[i * 8 +: 8]);
            rem = crc_next(rem, words[i * 8 +: 8]);
        end
        push_check_bytes(rem, spoil_head);
        if (with_body) begin
            rem = '0;
            for (int i = 0; i < int'(len) - 4; i++) begin
                b = 8'($urandom);
                blk_q.push_back(b);
                rem = crc_next(rem, b);
            end
            push_check_bytes(rem, spoil_body);
        end
    endtask

    task automatic make_noise(input int count);
        blk_q.delete();
        repeat (count) blk_q.push_back(8'($urandom));
    endtask

    // Moves the first count bytes of the block (all if negative) into the stream;
    // close marks the final stream byte as the end of the image.
    task automatic queue_bytes(input int count, input bit close);
        int n;
        n = (count < 0 || count > blk_q.size()) ? blk_q.size() : count;
        for (int i = 0; i < n; i++) begin
            stream_q.push_back('{data_byte: blk_q[i], last_byte: 1'b0});
        end
        if (close) stream_q[stream_q.size() - 1].last_byte = 1'b1;
    endtask

    initial begin
        logic [31:0] cmd;
        logic [31:0] base;
        logic [31:0] len;
        logic [31:0] lo16;
        logic [11:0] top;
        int          pick;
        int          nblk;
        bit          closed;

        i_rst_n          = 1'b0;
        req_if.valid     = 1'b0;
        req_if.data_byte = '0;
        req_if.last_byte = 1'b0;

        // Directed images.
        // Good image: a tail-only block, a high-region block with base bits 16 to 19 set,
        // a command 4 block with nonzero length, which is an ordinary block, and the end
        // block arriving on the image's last byte.
        build_block(32'h1, 32'h0000_0010, 32'd4, 1'b1, 1'b0, 1'b0);
        queue_bytes(-1, 1'b0);
        build_block(32'h2, 32'hC00F_1200, 32'd9, 1'b1, 1'b0, 1'b0);
        queue_bytes(-1, 1'b0);
        build_block(END_CMD, 32'h0000_0100, 32'd5, 1'b1, 1'b0, 1'b0);
        queue_bytes(-1, 1'b0);
        build_block(END_CMD, 32'h0, 32'd0, 1'b0, 1'b0, 1'b0);
        queue_bytes(-1, 1'b1);
        // Header CRC error; the body and trailing bytes are then ignored.
        build_block(32'h1, 32'h0000_0020, 32'd8, 1'b1, 1'b1, 1'b0);
        queue_bytes(-1, 1'b0);
        make_noise(2);
        queue_bytes(-1, 1'b1);
        // Length below the tail size.
        build_block(32'h3, 32'h0, 32'd3, 1'b0, 1'b0, 1'b0);
        queue_bytes(-1, 1'b0);
        make_noise(1);
        queue_bytes(-1, 1'b1);
        // Zero length with a command other than the end command, on the last byte.
        build_block(32'h5, 32'h0, 32'd0, 1'b0, 1'b0, 1'b0);
        queue_bytes(-1, 1'b1);
        // A valid header whose final byte ends the image.
        build_block(32'h1, 32'h0000_0040, 32'd8, 1'b0, 1'b0, 1'b0);
        queue_bytes(-1, 1'b1);
        // Window overrun by one byte.
        build_block(32'h1, 32'h0000_FFFF, 32'd6, 1'b0, 1'b0, 1'b0);
        queue_bytes(-1, 1'b0);
        make_noise(1);
        queue_bytes(-1, 1'b1);
        // Both regions filled to the top of the window, then the extents are reported.
        build_block(32'h7, 32'hC000_FF00, 32'd260, 1'b1, 1'b0, 1'b0);
        queue_bytes(-1, 1'b0);
        build_block(32'h7, 32'h0000_FFFC, 32'd8, 1'b1, 1'b0, 1'b0);
        queue_bytes(-1, 1'b0);
        build_block(END_CMD, 32'h0, 32'd0, 1'b0, 1'b0, 1'b0);
        queue_bytes(-1, 1'b1);
        // Invalid region with a good body, then with a bad body.
        build_block(32'h1, 32'h1234_0000, 32'd8, 1'b1, 1'b0, 1'b0);
        queue_bytes(-1, 1'b0);
        make_noise(1);
        queue_bytes(-1, 1'b1);
        build_block(32'h1, 32'h8000_0010, 32'd8, 1'b1, 1'b0, 1'b1);
        queue_bytes(-1, 1'b0);
        make_noise(1);
        queue_bytes(-1, 1'b1);
        // Body CRC error in the low region.
        build_block(32'h1, 32'h0000_0200, 32'd12, 1'b1, 1'b0, 1'b1);
        queue_bytes(-1, 1'b0);
        make_noise(1);
        queue_bytes(-1, 1'b1);
        // Image ends in the middle of a header.
        build_block(32'h1, 32'h0, 32'd8, 1'b1, 1'b0, 1'b0);
        queue_bytes(7, 1'b1);
        // Image ends on a payload byte, which reports ran-out instead of a write.
        build_block(32'h1, 32'hC000_0300, 32'd10, 1'b1, 1'b0, 1'b0);
        queue_bytes(19, 1'b1);
        // A block completing on the last byte, with no end block.
        build_block(32'h1, 32'h0000_0400, 32'd6, 1'b1, 1'b0, 1'b0);
        queue_bytes(-1, 1'b1);
        // A one-byte image.
        make_noise(1);
        queue_bytes(-1, 1'b1);
        directed_len = stream_q.size();

        // Random images: mostly well-formed blocks with random content, some broken.
        while (stream_q.size() - directed_len < RANDOM_BYTES) begin
            nblk   = $urandom_range(1, 4);
            closed = 1'b0;
            for (int n = 0; n < nblk && !closed; n++) begin
                pick = $urandom_range(99);
                len  = ($urandom_range(29) == 0) ? $urandom_range(41, 300)
                                                 : $urandom_range(4, 40);
                lo16 = $urandom_range(0, (len > 4) ? 65540 - len : 65535);
                case ($urandom_range(9))
                    0, 1, 2, 3: top = TOP_LOW;
                    4, 5, 6, 7: top = TOP_HIGH;
                    default: begin
                        do top = 12'($urandom); while (top == TOP_LOW || top == TOP_HIGH);
                    end
                endcase
                base = {top, 4'($urandom), lo16[15:0]};
                cmd  = $urandom;
                if (pick < 72) begin
                    build_block(cmd, base, len, 1'b1, $urandom_range(19) == 0,
                                $urandom_range(11) == 0);
                    queue_bytes(-1, 1'b0);
                end else if (pick < 90) begin
                    if (pick < 78) begin
                        // Short length; a zero length with the end command ends the image.
                        len = $urandom_range(0, 3);
                        if ($urandom_range(1)) cmd = END_CMD;
                    end else if (pick < 84) begin
                        lo16 = $urandom_range(0, 65535);
                        len  = $urandom_range(1) ? 65541 - lo16 + $urandom_range(0, 5000)
                                                 : ($urandom | 32'h0010_0000);
                    end
                    base[15:0] = lo16[15:0];
                    build_block(cmd, base, len, 1'b0, pick >= 84, 1'b0);
                    queue_bytes(-1, 1'b0);
                    make_noise($urandom_range(0, 3));
                    queue_bytes(-1, 1'b1);
                    closed = 1'b1;
                end else if (pick < 96) begin
                    build_block(cmd, base, len, 1'b1, 1'b0, 1'b0);
                    queue_bytes($urandom_range(1, blk_q.size() - 1), 1'b1);
                    closed = 1'b1;
                end else begin
                    make_noise($urandom_range(1, 20));
                    queue_bytes(-1, 1'b1);
                    closed = 1'b1;
                end
            end
            if (!closed) begin
                if ($urandom_range(9) < 8) begin
                    build_block(END_CMD, $urandom, 32'd0, 1'b0, 1'b0, 1'b0);
                    queue_bytes(-1, 1'b0);
                    make_noise($urandom_range(0, 3));
                    queue_bytes(-1, 1'b1);
                end else begin
                    queue_bytes(0, 1'b1);
                end
            end
        end
        pause_mid = directed_len + (stream_q.size() - directed_len) / 2;

        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Send every request; valid only changes at falling edges.
        for (int k = 0; k < stream_q.size(); k++) begin
            // Twice the sender holds off until every expected result has come back.
            if (k == directed_len || k == pause_mid) begin
                req_if.valid <= 1'b0;
                @(negedge i_clk);
                while (pending_count != 0) @(negedge i_clk);
            end
            while (!calm && $urandom_range(99) < IDLE_PERCENT) begin
                req_if.valid <= 1'b0;
                @(negedge i_clk);
            end
            req_if.valid     <= 1'b1;
            req_if.data_byte <= stream_q[k].data_byte;
            req_if.last_byte <= stream_q[k].last_byte;
            @(posedge i_clk);
            while (!req_if.ready) @(posedge i_clk);
            @(negedge i_clk);
        end
        req_if.valid <= 1'b0;

        // Drain, then give the registered result path time to show anything stray.
        while (pending_count != 0) @(negedge i_clk);
        repeat (10) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
